>>> hdl/wtacc_pkg.sv
// ----------------------------------------------------------------------------
// wtacc_pkg
// Shared types and constants for the waypoint time accumulator.
// ----------------------------------------------------------------------------
package wtacc_pkg;

    localparam int COORD_W   = 32;  // Q16.16 coordinate
    localparam int LIMIT_W   = 32;  // Q16.16 velocity / acceleration limit
    localparam int SUM_W     = 64;  // Q32.32 sum of squares
    localparam int TIME_W    = 48;  // Q32.16 time
    localparam int WORK_W    = 66;  // dividend / radicand shift register
    localparam int REM_W     = 36;  // partial remainder of the shared unit
    localparam int ROOT_W    = 33;  // square root result
    localparam int STEP_W    = 7;   // step counter of the shared unit
    localparam int CFG_IDX_W = 1;

    localparam logic [TIME_W-1:0]  TIME_MAX    = 48'hFFFF_FFFF_FFFF;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'h0001_0000;
    localparam logic [LIMIT_W-1:0] LIMIT_MIN   = 32'h0000_0001;

    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT    = 1'b1;

    // step counts: one quotient bit or one root bit per step
    localparam logic [STEP_W-1:0] DIST_STEPS    = 7'd32;  // sqrt of 64-bit sum
    localparam logic [STEP_W-1:0] TV_STEPS      = 7'd48;  // 48-bit dividend
    localparam logic [STEP_W-1:0] TA_DIV_STEPS  = 7'd65;  // 65-bit dividend
    localparam logic [STEP_W-1:0] TA_SQRT_STEPS = 7'd33;  // sqrt of 66-bit value

    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } t_unit_op;

    typedef struct packed {
        logic                start;
        t_unit_op            op;
        logic [STEP_W-1:0]   steps;
    } t_unit_cmd;

    typedef struct packed {
        logic rd_en;
        logic diff_en;
        logic mul_en;
        logic acc_en;
        logic end_item;
    } t_coord_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_DIFF,
        S_MUL,
        S_ACC,
        S_START_EMIT,
        S_DIST,
        S_DIST_WAIT,
        S_TV,
        S_TV_WAIT,
        S_TA_DIV,
        S_TA_DIV_WAIT,
        S_TA_SQRT,
        S_TA_SQRT_WAIT,
        S_ADD
    } t_state;

    typedef struct packed {
        logic signed [COORD_W-1:0] coordinate;
        logic                      last_coordinate;
        logic                      path_start;
    } t_in_word;

    typedef struct packed {
        logic [TIME_W-1:0] elapsed_time;
        logic              saturated;
    } t_out_word;

endpackage

>>> hdl/wtacc_unit.sv
// ----------------------------------------------------------------------------
// wtacc_unit
// Shared iterative restoring divider / digit-by-digit square root.
// ----------------------------------------------------------------------------
module wtacc_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  wtacc_pkg::t_unit_cmd               i_cmd,
    input  logic [wtacc_pkg::WORK_W-1:0]       i_operand,
    input  logic [wtacc_pkg::LIMIT_W-1:0]      i_divisor,
    output logic                               o_done,
    output logic [wtacc_pkg::WORK_W-1:0]       o_work,
    output logic [wtacc_pkg::ROOT_W-1:0]       o_root
);

    logic                                r_busy;
    logic                                r_done;
    logic [wtacc_pkg::STEP_W-1:0]        r_cnt;
    wtacc_pkg::t_unit_op                 r_op;
    logic [wtacc_pkg::WORK_W-1:0]        r_work;
    logic [wtacc_pkg::REM_W-1:0]         r_rem;
    logic [wtacc_pkg::ROOT_W-1:0]        r_root;
    logic [wtacc_pkg::LIMIT_W-1:0]       r_divisor;

    logic [wtacc_pkg::REM_W-1:0]         w_a;
    logic [wtacc_pkg::REM_W-1:0]         w_b;
    logic [wtacc_pkg::REM_W:0]           w_diff;
    logic                                w_ge;

    // one compare-subtract serves both operations
    always_comb begin
        if (r_op == wtacc_pkg::OP_DIV) begin
            w_a = {r_rem[wtacc_pkg::REM_W-2:0], r_work[wtacc_pkg::WORK_W-1]};
            w_b = {{(wtacc_pkg::REM_W-wtacc_pkg::LIMIT_W){1'b0}}, r_divisor};
        end else begin
            w_a = {r_rem[wtacc_pkg::REM_W-3:0], r_work[wtacc_pkg::WORK_W-1 -: 2]};
            w_b = {{(wtacc_pkg::REM_W-wtacc_pkg::ROOT_W-2){1'b0}}, r_root, 2'b01};
        end
        w_diff = {1'b0, w_a} - {1'b0, w_b};
        w_ge   = ~w_diff[wtacc_pkg::REM_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_cmd.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - wtacc_pkg::STEP_W'(1);
                if (r_cnt == wtacc_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op      <= i_cmd.op;
            r_work    <= i_operand;
            r_rem     <= '0;
            r_root    <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[wtacc_pkg::REM_W-1:0] : w_a;
            if (r_op == wtacc_pkg::OP_DIV) begin
                // quotient bits enter at the bottom as the dividend leaves the top
                r_work <= {r_work[wtacc_pkg::WORK_W-2:0], w_ge};
            end else begin
                r_work <= {r_work[wtacc_pkg::WORK_W-3:0], 2'b00};
                r_root <= {r_root[wtacc_pkg::ROOT_W-2:0], w_ge};
            end
        end
    end

    assign o_done = r_done;
    assign o_work = r_work;
    assign o_root = r_root;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> !r_busy)
        else $error("shared unit started while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_busy) && !r_busy))
        else $error("shared unit done without a finished run");
`endif

endmodule

>>> hdl/wtacc_coord.sv
// ----------------------------------------------------------------------------
// wtacc_coord
// Previous-point store, coordinate difference, square and saturating sum.
// ----------------------------------------------------------------------------
module wtacc_coord #(
    parameter int MAX_DOF = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  wtacc_pkg::t_coord_ctl                i_ctl,
    input  logic signed [wtacc_pkg::COORD_W-1:0] i_coord,
    output logic [wtacc_pkg::SUM_W-1:0]          o_sum,
    output logic                                 o_sat
);

    localparam int IDX_W = (MAX_DOF > 1) ? $clog2(MAX_DOF) : 1;
    localparam int CNT_W = $clog2(MAX_DOF + 1);

    logic [wtacc_pkg::COORD_W-1:0]  r_prev [MAX_DOF];
    logic [wtacc_pkg::COORD_W-1:0]  r_prev_rd;
    logic [CNT_W-1:0]               r_idx;
    logic                           r_active;
    logic [wtacc_pkg::COORD_W-1:0]  r_mag;
    logic [wtacc_pkg::SUM_W-1:0]    r_sq;
    logic [wtacc_pkg::SUM_W-1:0]    r_sum;

    logic                           w_room;
    logic [wtacc_pkg::COORD_W:0]    w_diff;
    logic [wtacc_pkg::COORD_W:0]    w_abs;
    logic [wtacc_pkg::SUM_W:0]      w_add;

    assign w_room = (r_idx < CNT_W'(MAX_DOF));

    // 33-bit difference; its magnitude always fits 32 bits
    always_comb begin
        w_diff = {i_coord[wtacc_pkg::COORD_W-1], i_coord}
               - {r_prev_rd[wtacc_pkg::COORD_W-1], r_prev_rd};
        w_abs  = w_diff[wtacc_pkg::COORD_W] ? (~w_diff + 1'b1) : w_diff;
        w_add  = {1'b0, r_sum} + {1'b0, r_sq};
    end

    // read-before-write on the same entry
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en && w_room) begin
            r_prev_rd                <= r_prev[r_idx[IDX_W-1:0]];
            r_prev[r_idx[IDX_W-1:0]] <= i_coord;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.diff_en) begin
            r_mag <= w_abs[wtacc_pkg::COORD_W-1:0];
        end
        if (i_ctl.mul_en) begin
            r_sq <= r_mag * r_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_active <= 1'b0;
            r_sum    <= '0;
        end else if (i_ctl.end_item) begin
            r_idx <= '0;
            r_sum <= '0;
        end else begin
            if (i_ctl.rd_en) begin
                r_active <= w_room;
                if (w_room) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
            end
            if (i_ctl.acc_en && r_active) begin
                r_sum <= w_add[wtacc_pkg::SUM_W] ? {wtacc_pkg::SUM_W{1'b1}}
                                                 : w_add[wtacc_pkg::SUM_W-1:0];
            end
        end
    end

    assign o_sum = r_sum;
    assign o_sat = i_ctl.acc_en & r_active & w_add[wtacc_pkg::SUM_W];

endmodule

>>> hdl/waypoint_time_accumulator_top.sv
// ----------------------------------------------------------------------------
// waypoint_time_accumulator_top
// Coordinate word (not last): read, diff, square, add; the next word is taken after the add.
// Last coordinate of a path start: the zero result word is loaded once the
// output register is free, and the next word is accepted after that.
// Other last coordinate: the result is set by the shared divide/root unit (one bit per
// cycle: 32 + 48 + 65 + 33 steps); the next word is accepted after the result is loaded.
// Reset (sync, active low) clears sequencer, sums, running time and limits
// (both limits to 1.0); the previous-point store is undefined until written.
// ----------------------------------------------------------------------------
module waypoint_time_accumulator_top #(
    parameter int MAX_DOF = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input words: one coordinate each
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  wtacc_pkg::t_in_word                  i_in,
    // result words: cumulative time per waypoint
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output wtacc_pkg::t_out_word                 o_out,
    // configuration writes
    input  logic                                 i_cfg_we,
    input  logic [wtacc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [wtacc_pkg::LIMIT_W-1:0]        i_cfg_data
);

    wtacc_pkg::t_state                     r_state;
    wtacc_pkg::t_state                     n_state;

    wtacc_pkg::t_in_word                   r_item;
    logic [wtacc_pkg::LIMIT_W-1:0]         r_vmax;
    logic [wtacc_pkg::LIMIT_W-1:0]         r_amax;
    logic [wtacc_pkg::TIME_W-1:0]          r_running;
    logic                                  r_sticky;
    logic [wtacc_pkg::COORD_W-1:0]         r_dist;
    logic [wtacc_pkg::TIME_W-1:0]          r_tv;
    logic [wtacc_pkg::TIME_W-1:0]          r_seg;
    wtacc_pkg::t_out_word                  r_out;
    logic                                  r_out_valid;

    wtacc_pkg::t_coord_ctl                 w_ctl;
    wtacc_pkg::t_unit_cmd                  w_cmd;
    logic [wtacc_pkg::WORK_W-1:0]          w_operand;
    logic [wtacc_pkg::LIMIT_W-1:0]         w_divisor;
    logic                                  w_in_ready;
    logic                                  w_out_free;
    logic                                  w_out_load;
    logic [wtacc_pkg::LIMIT_W-1:0]         w_vmax;
    logic [wtacc_pkg::LIMIT_W-1:0]         w_amax;
    logic [wtacc_pkg::TIME_W-1:0]          w_ta;
    logic [wtacc_pkg::TIME_W:0]            w_run_add;

    logic [wtacc_pkg::SUM_W-1:0]           c_sum;
    logic                                  c_sat;
    logic                                  u_done;
    logic [wtacc_pkg::WORK_W-1:0]          u_work;
    logic [wtacc_pkg::ROOT_W-1:0]          u_root;

    // ---------------------------------------------------------------
    // Per-coordinate path: store read/write, difference, square, sum
    // ---------------------------------------------------------------
    wtacc_coord #(
        .MAX_DOF (MAX_DOF)
    ) u_coord (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_coord (r_item.coordinate),
        .o_sum   (c_sum),
        .o_sat   (c_sat)
    );

    // ---------------------------------------------------------------
    // Shared divide / square root unit, one bit per cycle
    // ---------------------------------------------------------------
    wtacc_unit u_unit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_operand (w_operand),
        .i_divisor (w_divisor),
        .o_done    (u_done),
        .o_work    (u_work),
        .o_root    (u_root)
    );

    // a zero limit behaves as the smallest nonzero limit
    assign w_vmax = (r_vmax == '0) ? wtacc_pkg::LIMIT_MIN : r_vmax;
    assign w_amax = (r_amax == '0) ? wtacc_pkg::LIMIT_MIN : r_amax;

    assign w_ta      = {{(wtacc_pkg::TIME_W-wtacc_pkg::ROOT_W){1'b0}}, u_root};
    assign w_run_add = {1'b0, r_running} + {1'b0, r_seg};

    // the output register is free when empty or being drained this cycle
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_out_load = w_out_free
                     && ((r_state == wtacc_pkg::S_START_EMIT) || (r_state == wtacc_pkg::S_ADD));

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wtacc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_ctl      = '0;
        w_cmd      = '0;
        w_operand  = '0;
        w_divisor  = '0;
        w_in_ready = 1'b0;
        unique case (r_state)
            wtacc_pkg::S_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = wtacc_pkg::S_READ;
                end
            end
            wtacc_pkg::S_READ: begin
                w_ctl.rd_en = 1'b1;
                n_state     = wtacc_pkg::S_DIFF;
            end
            wtacc_pkg::S_DIFF: begin
                w_ctl.diff_en = 1'b1;
                n_state       = wtacc_pkg::S_MUL;
            end
            wtacc_pkg::S_MUL: begin
                w_ctl.mul_en = 1'b1;
                n_state      = wtacc_pkg::S_ACC;
            end
            wtacc_pkg::S_ACC: begin
                w_ctl.acc_en = 1'b1;
                if (!r_item.last_coordinate) begin
                    n_state = wtacc_pkg::S_IDLE;
                end else if (r_item.path_start) begin
                    n_state = wtacc_pkg::S_START_EMIT;
                end else begin
                    n_state = wtacc_pkg::S_DIST;
                end
            end
            wtacc_pkg::S_START_EMIT: begin
                w_ctl.end_item = 1'b1;
                if (w_out_free) begin
                    n_state = wtacc_pkg::S_IDLE;
                end
            end
            wtacc_pkg::S_DIST: begin
                // distance = isqrt(sum); the sum is cleared on the same edge
                w_ctl.end_item = 1'b1;
                w_cmd.start    = 1'b1;
                w_cmd.op       = wtacc_pkg::OP_SQRT;
                w_cmd.steps    = wtacc_pkg::DIST_STEPS;
                w_operand      = {c_sum, 2'b00};
                n_state        = wtacc_pkg::S_DIST_WAIT;
            end
            wtacc_pkg::S_DIST_WAIT: begin
                if (u_done) begin
                    n_state = wtacc_pkg::S_TV;
                end
            end
            wtacc_pkg::S_TV: begin
                // velocity time = (d << 16) / vmax, dividend left-aligned
                w_cmd.start = 1'b1;
                w_cmd.op    = wtacc_pkg::OP_DIV;
                w_cmd.steps = wtacc_pkg::TV_STEPS;
                w_operand   = {r_dist, 34'd0};
                w_divisor   = w_vmax;
                n_state     = wtacc_pkg::S_TV_WAIT;
            end
            wtacc_pkg::S_TV_WAIT: begin
                if (u_done) begin
                    n_state = wtacc_pkg::S_TA_DIV;
                end
            end
            wtacc_pkg::S_TA_DIV: begin
                // (2d << 32) / amax: 65-bit dividend, left-aligned
                w_cmd.start = 1'b1;
                w_cmd.op    = wtacc_pkg::OP_DIV;
                w_cmd.steps = wtacc_pkg::TA_DIV_STEPS;
                w_operand   = {r_dist, 34'd0};
                w_divisor   = w_amax;
                n_state     = wtacc_pkg::S_TA_DIV_WAIT;
            end
            wtacc_pkg::S_TA_DIV_WAIT: begin
                if (u_done) begin
                    n_state = wtacc_pkg::S_TA_SQRT;
                end
            end
            wtacc_pkg::S_TA_SQRT: begin
                w_cmd.start = 1'b1;
                w_cmd.op    = wtacc_pkg::OP_SQRT;
                w_cmd.steps = wtacc_pkg::TA_SQRT_STEPS;
                w_operand   = {1'b0, u_work[wtacc_pkg::WORK_W-2:0]};
                n_state     = wtacc_pkg::S_TA_SQRT_WAIT;
            end
            wtacc_pkg::S_TA_SQRT_WAIT: begin
                if (u_done) begin
                    n_state = wtacc_pkg::S_ADD;
                end
            end
            wtacc_pkg::S_ADD: begin
                if (w_out_free) begin
                    n_state = wtacc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wtacc_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vmax <= wtacc_pkg::LIMIT_RESET;
            r_amax <= wtacc_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wtacc_pkg::REG_VELOCITY_LIMIT: r_vmax <= i_cfg_data;
                wtacc_pkg::REG_ACCEL_LIMIT:    r_amax <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Running time, sticky flag and output word valid
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= '0;
            r_sticky    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == wtacc_pkg::S_ACC) && c_sat) begin
                r_sticky <= 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_out_load && (r_state == wtacc_pkg::S_START_EMIT)) begin
                r_running <= '0;
                r_sticky  <= 1'b0;
            end else if (w_out_load) begin
                if (w_run_add[wtacc_pkg::TIME_W]) begin
                    r_running <= wtacc_pkg::TIME_MAX;
                    r_sticky  <= 1'b1;
                end else begin
                    r_running <= w_run_add[wtacc_pkg::TIME_W-1:0];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (i_in_valid && w_in_ready) begin
            r_item <= i_in;
        end
        if ((r_state == wtacc_pkg::S_DIST_WAIT) && u_done) begin
            r_dist <= u_root[wtacc_pkg::COORD_W-1:0];
        end
        if ((r_state == wtacc_pkg::S_TV_WAIT) && u_done) begin
            r_tv <= u_work[wtacc_pkg::TIME_W-1:0];
        end
        // segment time = max(velocity time, acceleration time)
        if ((r_state == wtacc_pkg::S_TA_SQRT_WAIT) && u_done) begin
            r_seg <= (r_tv > w_ta) ? r_tv : w_ta;
        end
        if (w_out_load) begin
            if (r_state == wtacc_pkg::S_START_EMIT) begin
                r_out <= '0;
            end else begin
                r_out.elapsed_time <= w_run_add[wtacc_pkg::TIME_W] ? wtacc_pkg::TIME_MAX
                                                                 : w_run_add[wtacc_pkg::TIME_W-1:0];
                r_out.saturated    <= r_sticky | w_run_add[wtacc_pkg::TIME_W];
            end
        end
    end

    assign o_in_ready  = w_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTH
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        u_done |-> ((r_state == wtacc_pkg::S_DIST_WAIT) || (r_state == wtacc_pkg::S_TV_WAIT)
                 || (r_state == wtacc_pkg::S_TA_DIV_WAIT)
                 || (r_state == wtacc_pkg::S_TA_SQRT_WAIT)))
        else $error("shared unit finished outside a wait state");

    a_running_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wtacc_pkg::S_ADD) |=> (r_running >= $past(r_running)))
        else $error("running time decreased on a segment add");
`endif

endmodule

>>> sim/waypoint_time_accumulator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_time_accumulator_top_tb
// Self-checking bench for the waypoint time accumulator. Paths of waypoints
// are streamed one coordinate word at a time. A scoreboard class rebuilds
// each waypoint's distance, segment time and running time in plain integer
// math, and compares the result words in order. Runs through several limit
// settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module waypoint_time_accumulator_top_tb;

    localparam int DOF = 8;

    // coordinates that sit on the corners of the signed Q16.16 range
    localparam logic [wtacc_pkg::COORD_W-1:0] CORNER_COORDS [5] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001
    };

    typedef enum {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the block state, computes the
    // expected result word on every accepted last coordinate word, and checks
    // result words against the oldest expectation.
    // ------------------------------------------------------------------------
    class elapsed_time_scoreboard;
        logic [wtacc_pkg::LIMIT_W-1:0] vel_limit;
        logic [wtacc_pkg::LIMIT_W-1:0] acc_limit;
        logic [wtacc_pkg::COORD_W-1:0] prev_pt [DOF];
        int unsigned                   coord_idx;
        logic [wtacc_pkg::SUM_W-1:0]   sq_sum;
        logic [wtacc_pkg::TIME_W-1:0]  run_time;
        logic                          sat;
        wtacc_pkg::t_out_word          expected_q [$];
        int                            errors;

        function new();
            vel_limit = wtacc_pkg::LIMIT_RESET;
            acc_limit = wtacc_pkg::LIMIT_RESET;
            foreach (prev_pt[i]) prev_pt[i] = '0;
            coord_idx = 0;
            sq_sum    = '0;
            run_time  = '0;
            sat       = 1'b0;
            errors    = 0;
        endfunction

        // floor(sqrt(v)), one root bit per bit pair
        static function logic [32:0] root_floor(input logic [65:0] v);
            logic [67:0] rem;
            logic [67:0] root;
            logic [67:0] trial;
            rem  = '0;
            root = '0;
            for (int k = 32; k >= 0; k--) begin
                rem   = (rem << 2) | {66'd0, v[2*k +: 2]};
                trial = (root << 2) | 68'd1;
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = (root << 1) | 68'd1;
                end else begin
                    root = root << 1;
                end
            end
            return root[32:0];
        endfunction

        function void set_limit(input logic [wtacc_pkg::CFG_IDX_W-1:0] idx,
                                input logic [wtacc_pkg::LIMIT_W-1:0] val);
            if (idx == wtacc_pkg::REG_VELOCITY_LIMIT) begin
                vel_limit = val;
            end else if (idx == wtacc_pkg::REG_ACCEL_LIMIT) begin
                acc_limit = val;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_word(input wtacc_pkg::t_in_word w);
            logic [32:0]                   diff;
            logic [32:0]                   mag;
            logic [63:0]                   sq;
            logic [64:0]                   acc;
            logic [32:0]                   path_len;
            logic [wtacc_pkg::LIMIT_W-1:0] vmax;
            logic [wtacc_pkg::LIMIT_W-1:0] amax;
            logic [47:0]                   tv;
            logic [65:0]                   radicand;
            logic [32:0]                   ta;
            logic [47:0]                   seg;
            logic [48:0]                   total;
            wtacc_pkg::t_out_word          res;

            // accumulate squared difference for the first DOF coordinates
            if (coord_idx < DOF) begin
                diff = {w.coordinate[31], w.coordinate}
                     - {prev_pt[coord_idx][31], prev_pt[coord_idx]};
                mag  = diff[32] ? -diff : diff;
                prev_pt[coord_idx] = w.coordinate;
                sq   = mag[31:0] * mag[31:0];
                acc  = {1'b0, sq_sum} + {1'b0, sq};
                if (mag[32] || acc[64]) begin
                    sq_sum = '1;
                    sat    = 1'b1;
                end else begin
                    sq_sum = acc[63:0];
                end
                coord_idx++;
            end

            if (!w.last_coordinate) return;

            coord_idx = 0;
            if (w.path_start) begin
                sq_sum   = '0;
                run_time = '0;
                sat      = 1'b0;
                res      = '0;
            end else begin
                path_len = root_floor({2'b00, sq_sum});
                sq_sum   = '0;
                // a zero limit behaves as the smallest nonzero one
                vmax = (vel_limit == '0) ? wtacc_pkg::LIMIT_MIN : vel_limit;
                amax = (acc_limit == '0) ? wtacc_pkg::LIMIT_MIN : acc_limit;
                tv       = {path_len[31:0], 16'h0} / {16'h0, vmax};
                radicand = {1'b0, path_len[31:0], 33'h0} / {34'h0, amax};
                ta       = root_floor(radicand);
                seg      = (tv > {15'h0, ta}) ? tv : {15'h0, ta};
                total    = {1'b0, run_time} + {1'b0, seg};
                if (total[48]) begin
                    run_time = wtacc_pkg::TIME_MAX;
                    sat      = 1'b1;
                end else begin
                    run_time = total[47:0];
                end
                res.elapsed_time = run_time;
                res.saturated    = sat;
            end
            expected_q.insert(expected_q.size(), res);
        endfunction

        function void check_result(input wtacc_pkg::t_out_word got);
            wtacc_pkg::t_out_word want;
            if (expected_q.size() == 0) begin
                $display("%0t: result with none expected: actual time %h, saturated %b",
                         $time, got.elapsed_time, got.saturated);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.elapsed_time !== want.elapsed_time) begin
                $display("%0t: elapsed_time mismatch: expected %h, actual %h",
                         $time, want.elapsed_time, got.elapsed_time);
                errors++;
            end
            if (got.saturated !== want.saturated) begin
                $display("%0t: saturated mismatch: expected %b, actual %b",
                         $time, want.saturated, got.saturated);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals; every input known from time zero
    // ------------------------------------------------------------------------
    logic                            i_clk;
    logic                            i_rst_n    = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    wtacc_pkg::t_in_word             i_in       = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    wtacc_pkg::t_out_word            o_out;
    logic                            i_cfg_we   = 1'b0;
    logic [wtacc_pkg::CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [wtacc_pkg::LIMIT_W-1:0]   i_cfg_data = '0;

    elapsed_time_scoreboard sb;

    int unsigned                   send_idle_pct = 0;   // chance per cycle that the sender holds off
    int unsigned                   recv_stall_pct = 0;  // chance per cycle that ready is low
    int unsigned                   word_count = 0;      // accepted input words
    logic [wtacc_pkg::COORD_W-1:0] last_sent [DOF];     // mirror of what the block stores per axis

    waypoint_time_accumulator_top #(
        .MAX_DOF (DOF)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stalls, sampled on the same edge that the DUT sees
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result monitor: a word moves when valid and ready were both high
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_out);
        end
    end

    // hard stop in case the handshake hangs
    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one coordinate word; valid stays up across back-to-back words
    // and only drops during a sender gap.
    task automatic drive_word(input wtacc_pkg::t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= w;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(w);
        word_count++;
    endtask

    // One waypoint: path_start only matters on the last word, so it is
    // random on the others.
    task automatic send_points(input logic [wtacc_pkg::COORD_W-1:0] pts [$], input bit start);
        wtacc_pkg::t_in_word w;
        for (int i = 0; i < pts.size(); i++) begin
            w.coordinate      = pts[i];
            w.last_coordinate = (i == pts.size() - 1);
            w.path_start      = (i == pts.size() - 1) ? start : 1'($urandom_range(1));
            if (i < DOF) last_sent[i] = pts[i];
            drive_word(w);
        end
    endtask

    // Sender stops and lets everything in flight come out, then a short
    // hold-off so that a trailing non-last word is done too.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    // Both limits, back to back, while the block is idle.
    task automatic write_limits(input logic [wtacc_pkg::LIMIT_W-1:0] vel,
                                input logic [wtacc_pkg::LIMIT_W-1:0] acc);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= wtacc_pkg::REG_VELOCITY_LIMIT;
        i_cfg_data <= vel;
        @(posedge i_clk);
        sb.set_limit(wtacc_pkg::REG_VELOCITY_LIMIT, vel);
        i_cfg_idx  <= wtacc_pkg::REG_ACCEL_LIMIT;
        i_cfg_data <= acc;
        @(posedge i_clk);
        sb.set_limit(wtacc_pkg::REG_ACCEL_LIMIT, acc);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [wtacc_pkg::LIMIT_W-1:0] rand_limit();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(1, 255);
            2:       return 32'h0001_0000 + $urandom_range(0, 32'h3_FFFF);
            default: return $urandom_range(1) ? '0 : '1;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [wtacc_pkg::COORD_W-1:0] pts [$];
        logic [wtacc_pkg::LIMIT_W-1:0] vel;
        logic [wtacc_pkg::LIMIT_W-1:0] acc;
        logic [wtacc_pkg::COORD_W-1:0] delta;
        logic [wtacc_pkg::COORD_W-1:0] coord_val;
        int unsigned                   phase_end;
        int unsigned                   path_dof;
        int unsigned                   n;
        int unsigned                   sel;
        int unsigned                   pick;
        bit                            start;
        t_idle_mode                    mode;

        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset limits (1.0 / 1.0), no idling.
        // Opening path start with too many coordinates: writes every axis,
        // and the two extra words must be ignored.
        pts = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000, 32'h5555_5555,
                32'hAAAA_AAAA, 32'h1234_5678};
        send_points(pts, 1'b1);
        // full-scale swing on two axes: square sum saturates, fewer axes
        pts = '{32'h8000_0000, 32'h7FFF_FFFF};
        send_points(pts, 1'b0);
        // zero distance, saturation flag stays sticky
        pts = '{32'h8000_0000};
        send_points(pts, 1'b0);
        // new path clears time and flag
        pts = '{32'h0000_0000};
        send_points(pts, 1'b1);
        pts = '{32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000};
        send_points(pts, 1'b0);
        // exactly DOF axes
        pts = '{32'h0001_8000, 32'hFFFE_0000, 32'h0000_0000, 32'h0000_0001,
                32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'h5555_5555};
        send_points(pts, 1'b0);
        drain();

        // Random phases: limit extremes first, then random limits; idle mix
        // rotates so that gaps land on every stage of the divide/root work.
        path_dof = DOF;
        for (int p = 1; p <= 8; p++) begin
            case (p)
                1:       begin vel = 32'h0000_0001; acc = 32'hFFFF_FFFF; end
                2:       begin vel = 32'hFFFF_FFFF; acc = 32'h0000_0001; end
                3:       begin vel = '0;            acc = '0;            end
                4:       begin
                    vel = wtacc_pkg::LIMIT_RESET;
                    acc = wtacc_pkg::LIMIT_RESET;
                end
                default: begin vel = rand_limit();  acc = rand_limit();  end
            endcase
            write_limits(vel, acc);

            mode = t_idle_mode'(p % 4);
            case (mode)
                IDLE_NONE:     begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
                IDLE_SENDER:   begin send_idle_pct <= 56; recv_stall_pct <= 0;  end
                IDLE_RECEIVER: begin send_idle_pct <= 0;  recv_stall_pct <= 56; end
                default:       begin send_idle_pct <= 35; recv_stall_pct <= 35; end
            endcase

            phase_end = word_count + 50;
            while (word_count < phase_end) begin
                // now and then the sender waits for every result to come out
                if ($urandom_range(24) == 0) drain();

                start = ($urandom_range(7) == 0);
                if (start) path_dof = $urandom_range(1, DOF);
                // mostly the path's own axis count; some short, some long
                sel = $urandom_range(9);
                if (sel == 0) begin
                    n = $urandom_range(1, path_dof);
                end else if (sel == 1) begin
                    n = $urandom_range(DOF + 1, DOF + 4);
                end else begin
                    n = path_dof;
                end

                pts.delete();
                for (int i = 0; i < n; i++) begin
                    pick = $urandom_range(99);
                    if (i >= DOF || pick >= 80) begin
                        coord_val = $urandom;
                    end else if (pick >= 60) begin
                        coord_val = CORNER_COORDS[$urandom_range(4)];
                    end else begin
                        // step of random magnitude from the stored point
                        delta     = $urandom >> $urandom_range(31, 6);
                        coord_val = $urandom_range(1) ? last_sent[i] + delta
                                                      : last_sent[i] - delta;
                    end
                    pts.insert(pts.size(), coord_val);
                end
                send_points(pts, start);
            end
            drain();
        end

        // results are all in; allow one full segment time for stray words
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
